@@ sv/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
// Each macro names the check, states a property on clk and reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/vva_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vva_pkg
// Shared types, constants and helpers of the Verlet atom update engine.
// ----------------------------------------------------------------------------
package vva_pkg;

  localparam int MAX_ATOMS   = 1024;
  localparam int ATOM_IDX_W  = $clog2(MAX_ATOMS);
  localparam int IDX_W       = 10;
  localparam int OP_W        = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int IN_TDATA_W  = 240;
  localparam int OUT_TDATA_W = 272;
  localparam int MOD_STEPS   = 47;
  localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

  // Operation codes of the input request.
  localparam logic [OP_W-1:0] OP_LOAD     = 3'd0;
  localparam logic [OP_W-1:0] OP_HALF     = 3'd1;
  localparam logic [OP_W-1:0] OP_DRIFT    = 3'd2;
  localparam logic [OP_W-1:0] OP_KDT      = 3'd3;
  localparam logic [OP_W-1:0] OP_SNAPSHOT = 3'd4;
  localparam logic [OP_W-1:0] OP_NONE     = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_TIME_STEP = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOX_X     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOX_Y     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOX_Z     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 3'd4;

  // Controller states; the datapath takes the same code as its command.
  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_LATCH, ST_KICK_MUL, ST_KICK_SCALE, ST_KICK_ADD,
    ST_DRIFT_MUL, ST_DRIFT_SUM, ST_MOD_STEP, ST_MOD_FIX, ST_TRACK_MUL,
    ST_TRACK_ACC, ST_COMMIT, ST_EMIT
  } state_t;

  typedef struct packed {
    state_t      op;
    logic [1:0]  axis;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            box_zero;
    logic            mod_done;
    logic            out_free;
  } dp_status_t;

  // Clamp a signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    logic signed [31:0] r;
    if (x > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -48'sh0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/vva_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vva_ram
// Single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module vva_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read on the one port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/vva_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vva_ctrl
// Sequencer that walks one request through its per-axis phases.
// ----------------------------------------------------------------------------
module vva_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  vva_pkg::dp_status_t status,
  output vva_pkg::dp_cmd_t    cmd
);
  import vva_pkg::*;

  state_t     state, state_next;
  logic [1:0] axis, axis_next;

  // State and axis registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= 2'd0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  // First phase of an axis for the current opcode.
  function automatic state_t first_phase(input logic [OP_W-1:0] op);
    state_t s;
    if (op == OP_DRIFT) begin
      s = ST_DRIFT_MUL;
    end else begin
      s = ST_KICK_MUL;
    end
    return s;
  endfunction

  // Next state and command.
  always_comb begin
    state_next = state;
    axis_next  = axis;
    s_tready   = 1'b0;
    cmd.op     = state;
    cmd.axis   = axis;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_READ;
          axis_next  = 2'd0;
        end
      end
      ST_READ: begin
        state_next = ST_LATCH;
      end
      ST_LATCH: begin
        if (status.opcode == OP_HALF || status.opcode == OP_DRIFT ||
            status.opcode == OP_KDT) begin
          state_next = first_phase(status.opcode);
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_KICK_MUL:   state_next = ST_KICK_SCALE;
      ST_KICK_SCALE: state_next = ST_KICK_ADD;
      ST_KICK_ADD: begin
        state_next = (status.opcode == OP_KDT) ? ST_DRIFT_MUL : ST_TRACK_ACC;
        if (status.opcode != OP_KDT) begin
          // Half kick alone: the axis is done.
          if (axis == 2'd2) begin
            state_next = ST_COMMIT;
          end else begin
            axis_next  = axis + 2'd1;
            state_next = first_phase(status.opcode);
          end
        end
      end
      ST_DRIFT_MUL: state_next = ST_DRIFT_SUM;
      ST_DRIFT_SUM, ST_MOD_FIX: begin
        if (state == ST_DRIFT_SUM && !status.box_zero) begin
          state_next = ST_MOD_STEP;
        end else if (status.opcode == OP_KDT) begin
          state_next = ST_TRACK_MUL;
        end else if (axis == 2'd2) begin
          state_next = ST_COMMIT;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = first_phase(status.opcode);
        end
      end
      ST_MOD_STEP: begin
        if (status.mod_done) begin
          state_next = ST_MOD_FIX;
        end
      end
      ST_TRACK_MUL: state_next = ST_TRACK_ACC;
      ST_TRACK_ACC: begin
        if (axis == 2'd2) begin
          state_next = ST_COMMIT;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = first_phase(status.opcode);
        end
      end
      ST_COMMIT: state_next = ST_EMIT;
      ST_EMIT: begin
        // Hold the result until the output register is free.
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ sv/vva_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vva_dp
// Datapath: atom stores, shared multiplier, modulo unit and result register.
// ----------------------------------------------------------------------------
module vva_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  vva_pkg::dp_cmd_t                      cmd,
  output vva_pkg::dp_status_t                   status,
  input  logic [vva_pkg::IN_TDATA_W-1:0]        s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [vva_pkg::OUT_TDATA_W-1:0]       m_tdata,
  input  logic                                  cfg_we,
  input  logic [vva_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [63:0]                           cfg_data
);
  import vva_pkg::*;

  // Configuration registers.
  logic [30:0] time_step;
  logic [30:0] box [3];
  logic [63:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 31'd66;
      box[0]    <= 31'd655360;
      box[1]    <= 31'd655360;
      box[2]    <= 31'd655360;
      threshold <= 64'h1_0000_0000;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TIME_STEP: time_step <= cfg_data[30:0];
        CFG_BOX_X:     box[0]    <= cfg_data[30:0];
        CFG_BOX_Y:     box[1]    <= cfg_data[30:0];
        CFG_BOX_Z:     box[2]    <= cfg_data[30:0];
        CFG_THRESHOLD: threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured request.
  logic [OP_W-1:0]    opcode;
  logic [IDX_W-1:0]   atom_idx;
  logic signed [31:0] fin [3];
  logic signed [31:0] lvel [3];
  logic [30:0]        inv_mass;
  logic               in_range;
  logic               in_range_q;

  assign in_range = 32'(s_tdata[12:3]) < 32'(MAX_ATOMS);

  always_ff @(posedge clk) begin
    if (cmd.op == ST_IDLE) begin
      opcode   <= in_range ? s_tdata[2:0] : OP_NONE;
      atom_idx <= s_tdata[12:3];
      fin[0]   <= s_tdata[44:13];
      fin[1]   <= s_tdata[76:45];
      fin[2]   <= s_tdata[108:77];
      lvel[0]  <= s_tdata[140:109];
      lvel[1]  <= s_tdata[172:141];
      lvel[2]  <= s_tdata[204:173];
      inv_mass <= s_tdata[235:205];
    end
  end

  // Atom stores.
  logic [ATOM_IDX_W-1:0] ram_addr;
  logic [95:0]           pos_rd, vel_rd, ref_rd;
  logic                  pv_we, ref_we;
  logic signed [31:0]    pos [3];
  logic signed [31:0]    vel [3];
  logic signed [31:0]    refp [3];

  assign ram_addr = ATOM_IDX_W'(atom_idx);
  assign pv_we  = (cmd.op == ST_COMMIT) && (opcode == OP_LOAD || opcode == OP_HALF ||
                  opcode == OP_DRIFT || opcode == OP_KDT);
  assign ref_we = (cmd.op == ST_COMMIT) && (opcode == OP_SNAPSHOT);

  vva_ram #(.WIDTH(96), .DEPTH(MAX_ATOMS)) u_pos_ram (
    .clk(clk), .we(pv_we), .addr(ram_addr),
    .wdata({pos[2], pos[1], pos[0]}), .rdata(pos_rd)
  );
  vva_ram #(.WIDTH(96), .DEPTH(MAX_ATOMS)) u_vel_ram (
    .clk(clk), .we(pv_we), .addr(ram_addr),
    .wdata({vel[2], vel[1], vel[0]}), .rdata(vel_rd)
  );
  vva_ram #(.WIDTH(96), .DEPTH(MAX_ATOMS)) u_ref_ram (
    .clk(clk), .we(ref_we), .addr(ram_addr),
    .wdata({pos[2], pos[1], pos[0]}), .rdata(ref_rd)
  );

  // Shared multiplier operands by phase.
  logic [1:0]         ax;
  logic [30:0]        box_sel;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [31:0] kick_a;
  logic signed [47:0] vsum, drift_s;
  logic signed [34:0] dd, d2, bx;
  logic [34:0]        dmag;

  assign ax      = cmd.axis;
  assign box_sel = box[ax];
  assign kick_a  = sat32(prod[63:16]);
  assign vsum    = 48'(vel[ax]) + 48'($signed(prod[63:17]));
  assign drift_s = 48'(pos[ax]) + prod[63:16];

  // Minimum image of the offset from the reference.
  always_comb begin
    bx = 35'(box_sel);
    dd = 35'(pos[ax]) - 35'(refp[ax]);
    d2 = dd <<< 1;
    if (d2 > bx) begin
      dd = dd - bx;
    end else if (d2 < -bx) begin
      dd = dd + bx;
    end
    dmag = dd[34] ? 35'(-dd) : 35'(dd);
  end

  always_comb begin
    mul_a = 33'(fin[ax]);
    mul_b = 33'(inv_mass);
    case (cmd.op)
      ST_KICK_SCALE: begin
        mul_a = 33'(kick_a);
        mul_b = 33'(time_step);
      end
      ST_DRIFT_MUL: begin
        mul_a = 33'(vel[ax]);
        mul_b = 33'(time_step);
      end
      ST_TRACK_MUL: begin
        mul_a = {1'b0, dmag[31:0]};
        mul_b = {1'b0, dmag[31:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Floored modulo: restoring remainder, one dividend bit a cycle.
  logic [46:0]          div_sh;
  logic [31:0]          rem, rem_try;
  logic                 s_neg;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [30:0]          rem_fix;

  assign rem_try = {rem[30:0], div_sh[46]};
  assign rem_fix = (s_neg && rem[30:0] != 31'd0) ? box_sel - rem[30:0] : rem[30:0];

  always_ff @(posedge clk) begin
    if (cmd.op == ST_DRIFT_SUM) begin
      s_neg   <= drift_s[47];
      div_sh  <= drift_s[47] ? 47'(-drift_s) : drift_s[46:0];
      rem     <= 32'd0;
      mod_cnt <= '0;
    end else if (cmd.op == ST_MOD_STEP) begin
      div_sh  <= {div_sh[45:0], 1'b0};
      rem     <= (rem_try >= {1'b0, box_sel}) ? rem_try - {1'b0, box_sel} : rem_try;
      mod_cnt <= mod_cnt + 1'b1;
    end
  end

  // Working copy of the atom, updated per axis.
  logic        msat;
  logic [63:0] sum, sq;
  logic [64:0] sum_add;
  logic [63:0] max_disp;

  assign sq      = msat ? '1 : prod[63:0];
  assign sum_add = {1'b0, sum} + {1'b0, sq};

  always_ff @(posedge clk) begin
    case (cmd.op)
      ST_READ: sum <= '0;
      ST_LATCH: begin
        for (int k = 0; k < 3; k++) begin
          if (opcode == OP_LOAD) begin
            pos[k] <= fin[k];
            vel[k] <= lvel[k];
          end else if (!in_range_q) begin
            pos[k] <= 32'sd0;
            vel[k] <= 32'sd0;
          end else begin
            pos[k] <= pos_rd[32*k +: 32];
            vel[k] <= vel_rd[32*k +: 32];
          end
          refp[k] <= ref_rd[32*k +: 32];
        end
      end
      ST_KICK_ADD: vel[ax] <= sat32(vsum);
      ST_DRIFT_SUM: begin
        if (box_sel == 31'd0) begin
          pos[ax] <= sat32(drift_s);
        end
      end
      ST_MOD_FIX:   pos[ax] <= {1'b0, rem_fix};
      ST_TRACK_MUL: msat <= dmag[34:32] != 3'd0;
      ST_TRACK_ACC: sum <= sum_add[64] ? '1 : sum_add[63:0];
      default: ;
    endcase
  end

  // Index range flag follows the captured request.
  always_ff @(posedge clk) begin
    if (cmd.op == ST_IDLE) begin
      in_range_q <= in_range;
    end
  end

  // Running maximum of the squared displacement.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_disp <= '0;
    end else if (cmd.op == ST_COMMIT) begin
      if (opcode == OP_SNAPSHOT) begin
        max_disp <= '0;
      end else if (opcode == OP_KDT && sum > max_disp) begin
        max_disp <= sum;
      end
    end
  end

  // Output register.
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ST_EMIT && out_free) begin
      m_tdata <= {5'd0, max_disp > (threshold >> 2), max_disp,
                  vel[2], vel[1], vel[0], pos[2], pos[1], pos[0], atom_idx};
    end
  end

  assign status.opcode   = opcode;
  assign status.box_zero = box_sel == 31'd0;
  assign status.mod_done = mod_cnt == MOD_CNT_W'(MOD_STEPS - 1);
  assign status.out_free = out_free;

endmodule

@@ sv/velocity_verlet_atom_update.sv @@
`timescale 1ns / 1ps
// Load, snapshot and unused opcodes go straight to the commit; a half kick, a drift
// and kick-drift-track run their phases on each of the three axes. A drift runs the
// 47-step remainder unit on each axis unless that axis has a zero box length.
// One request at a time; the next is taken while the last result still waits.
// Synchronous reset sets the configuration to its defaults and clears the maximum;
// the atom stores hold nothing defined until written.
// ----------------------------------------------------------------------------
// velocity_verlet_atom_update
// Velocity Verlet update of stored atoms in an orthogonal periodic box.
// ----------------------------------------------------------------------------
module velocity_verlet_atom_update (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // opcode, atom_index, pos_or_force_x/y/z, load_vel_x/y/z, inv_mass, zero pad
  input  logic [vva_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // result_index, pos_x/y/z, vel_x/y/z, max_disp_sq, rebuild_needed, zero pad
  output logic [vva_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [vva_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [63:0]                         cfg_data
);
  import vva_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  vva_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .status(status), .cmd(cmd)
  );

  vva_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

`include "assert_macros.svh"

  // A taken request keeps the block busy in the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // A result only appears out of a busy cycle.
  `ASSERT_SAME(a_result_from_work, $rose(m_tvalid), !$past(s_tready))
  // With no displacement recorded, no rebuild is flagged.
  `ASSERT_SAME(a_no_rebuild_at_zero, m_tvalid && m_tdata[265:202] == 64'd0, !m_tdata[266])

endmodule

@@ tb/sv/vva_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vva_checker
// Watches the request, result and configuration ports of the Verlet atom
// update engine. It keeps its own copy of the atom stores and registers,
// predicts each result and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module vva_checker
  import vva_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [63:0]            cfg_data,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [9:0]         idx;
    logic signed [31:0] px, py, pz;
    logic signed [31:0] vx, vy, vz;
    logic [63:0]        max_sq;
    logic               rebuild;
  } atom_result_t;

  // Shadow of the configuration registers.
  logic [30:0] dt;
  logic [30:0] box [3];
  logic [63:0] skin_sq;

  // Shadow of the atom stores and of the running maximum.
  logic signed [31:0] pos_mem [MAX_ATOMS][3];
  logic signed [31:0] vel_mem [MAX_ATOMS][3];
  logic signed [31:0] ref_mem [MAX_ATOMS][3];
  logic [63:0]        max_sq;

  atom_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // Half kick on one axis: v += (f * inv_mass) * dt / 2, with truncation.
  function automatic logic signed [31:0] kick_axis(input logic signed [31:0] v,
                                                   input logic signed [31:0] f,
                                                   input logic [30:0] im);
    longint fl, iml, al, dtl, dv, vl;
    fl  = f;
    iml = {33'd0, im};
    dtl = {33'd0, dt};
    vl  = v;
    al  = clamp32((fl * iml) >>> 16);
    dv  = (al * dtl) >>> 17;
    return clamp32(vl + dv);
  endfunction

  // Drift on one axis, then floored modulo into the box.
  function automatic logic signed [31:0] drift_axis(input logic signed [31:0] p,
                                                    input logic signed [31:0] v,
                                                    input logic [30:0] b);
    longint pl, vl, dtl, bl, s, r;
    pl  = p;
    vl  = v;
    dtl = {33'd0, dt};
    bl  = {33'd0, b};
    s   = pl + ((vl * dtl) >>> 16);
    if (bl == 0) return clamp32(s);
    r = s % bl;
    if (r < 0) r = r + bl;
    return r[31:0];
  endfunction

  // Minimum-image offset from the reference, squared with saturation.
  function automatic logic [63:0] image_sq(input logic signed [31:0] p,
                                           input logic signed [31:0] r,
                                           input logic [30:0] b);
    longint d, bl, m;
    logic [63:0] mu;
    d  = longint'(p) - longint'(r);
    bl = {33'd0, b};
    if (2 * d > bl) d = d - bl;
    else if (2 * d < -bl) d = d + bl;
    m = (d < 0) ? -d : d;
    if (m > 64'sh0000_0000_FFFF_FFFF) return '1;
    mu = m;
    return mu * mu;
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Applies one request to the shadow state and queues its result.
  task automatic predict_atom(input logic [IN_TDATA_W-1:0] req);
    logic [OP_W-1:0]    op;
    logic [9:0]         idx;
    logic signed [31:0] f [3];
    logic signed [31:0] lv [3];
    logic [30:0]        im;
    logic [63:0]        sum;
    atom_result_t       res;
    op  = req[2:0];
    idx = req[12:3];
    im  = req[235:205];
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      f[k]  = req[13 + 32*k +: 32];
      lv[k] = req[109 + 32*k +: 32];
    end
    case (op)
      OP_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          pos_mem[idx][k] = f[k];
          vel_mem[idx][k] = lv[k];
        end
      end
      OP_HALF: begin
        for (int k = 0; k < 3; k++) vel_mem[idx][k] = kick_axis(vel_mem[idx][k], f[k], im);
      end
      OP_DRIFT: begin
        for (int k = 0; k < 3; k++)
          pos_mem[idx][k] = drift_axis(pos_mem[idx][k], vel_mem[idx][k], box[k]);
      end
      OP_KDT: begin
        for (int k = 0; k < 3; k++) begin
          vel_mem[idx][k] = kick_axis(vel_mem[idx][k], f[k], im);
          pos_mem[idx][k] = drift_axis(pos_mem[idx][k], vel_mem[idx][k], box[k]);
          sum = add_sat(sum, image_sq(pos_mem[idx][k], ref_mem[idx][k], box[k]));
        end
        if (sum > max_sq) max_sq = sum;
      end
      OP_SNAPSHOT: begin
        for (int k = 0; k < 3; k++) ref_mem[idx][k] = pos_mem[idx][k];
        max_sq = '0;
      end
      default: begin
        // Unused codes leave the entry as it is.
      end
    endcase
    res.idx     = idx;
    res.px      = pos_mem[idx][0];
    res.py      = pos_mem[idx][1];
    res.pz      = pos_mem[idx][2];
    res.vx      = vel_mem[idx][0];
    res.vy      = vel_mem[idx][1];
    res.vz      = vel_mem[idx][2];
    res.max_sq  = max_sq;
    res.rebuild = max_sq > (skin_sq >> 2);
    expected_results.push_back(res);
  endtask

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
    fail_count++;
  endtask

  // Compares one result with the oldest prediction.
  task automatic compare_result(input logic [OUT_TDATA_W-1:0] rsp);
    atom_result_t want;
    if (expected_results.size() == 0) begin
      report("result with nothing expected", 64'd0, rsp[63:0]);
      return;
    end
    want = expected_results.pop_front();
    if (rsp[9:0] !== want.idx) report("result_index", want.idx, rsp[9:0]);
    if (rsp[41:10] !== want.px) report("pos_x", want.px, rsp[41:10]);
    if (rsp[73:42] !== want.py) report("pos_y", want.py, rsp[73:42]);
    if (rsp[105:74] !== want.pz) report("pos_z", want.pz, rsp[105:74]);
    if (rsp[137:106] !== want.vx) report("vel_x", want.vx, rsp[137:106]);
    if (rsp[169:138] !== want.vy) report("vel_y", want.vy, rsp[169:138]);
    if (rsp[201:170] !== want.vz) report("vel_z", want.vz, rsp[201:170]);
    if (rsp[265:202] !== want.max_sq) report("max_disp_sq", want.max_sq, rsp[265:202]);
    if (rsp[266] !== want.rebuild) report("rebuild_needed", want.rebuild, rsp[266]);
  endtask

  initial fail_count = 0;

  // Track register writes, requests and results on every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      dt      <= 31'd66;
      box[0]  <= 31'd655360;
      box[1]  <= 31'd655360;
      box[2]  <= 31'd655360;
      skin_sq <= 64'h1_0000_0000;
      max_sq  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TIME_STEP: dt <= cfg_data[30:0];
          CFG_BOX_X:     box[0] <= cfg_data[30:0];
          CFG_BOX_Y:     box[1] <= cfg_data[30:0];
          CFG_BOX_Z:     box[2] <= cfg_data[30:0];
          CFG_THRESHOLD: skin_sq <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) compare_result(m_tdata);
      if (s_tvalid && s_tready) predict_atom(s_tdata);
    end
  end

endmodule

@@ tb/sv/velocity_verlet_atom_update_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_verlet_atom_update_tb
// Drives load, kick, drift, tracking and snapshot requests into the engine
// under several register settings with random gaps and stalls on both
// sides; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module velocity_verlet_atom_update_tb;
  import vva_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [63:0]            cfg_data;
  int                     fail_count;
  int                     pending;
  int                     n_sent;
  int                     n_recv;
  int                     idle_cycles;
  int                     hold_cycles;
  bit                     loaded [MAX_ATOMS];
  bit                     has_ref [MAX_ATOMS];

  velocity_verlet_atom_update u_top (.*);

  vva_checker u_checker (.*);

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count accepted requests and results; watchdog on stalled progress.
  always @(posedge clk) begin
    if (s_tvalid && s_tready) n_sent <= n_sent + 1;
    if (m_tvalid && m_tready) n_recv <= n_recv + 1;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 20000) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver with random stalls and an optional long hold-off.
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      gap = $urandom_range(0, 5);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Stops offering requests and waits until every result has come back.
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (n_recv != n_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_regs(input logic [30:0] dt, input logic [30:0] bx,
                          input logic [30:0] by, input logic [30:0] bz,
                          input logic [63:0] skin);
    wait_drain();
    repeat (200) @(posedge clk);
    write_reg(CFG_TIME_STEP, {33'd0, dt});
    write_reg(CFG_BOX_X, {33'd0, bx});
    write_reg(CFG_BOX_Y, {33'd0, by});
    write_reg(CFG_BOX_Z, {33'd0, bz});
    write_reg(CFG_THRESHOLD, skin);
  endtask

  // Sends one request after a random gap and waits for it to be taken.
  task automatic send_atom(input logic [OP_W-1:0] op, input logic [9:0] idx,
                           input logic [31:0] fx, input logic [31:0] fy,
                           input logic [31:0] fz, input logic [31:0] vx,
                           input logic [31:0] vy, input logic [31:0] vz,
                           input logic [30:0] im);
    int gap;
    gap = $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {4'd0, im, vz, vy, vx, fz, fy, fx, idx, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (op == OP_LOAD) loaded[idx] = 1'b1;
    if (op == OP_SNAPSHOT) has_ref[idx] = 1'b1;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1 << 22);
      3: return -$urandom_range(0, 1 << 22);
      4: return $urandom >>> $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_mass();
    case ($urandom_range(0, 4))
      0: return 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return $urandom_range(0, 1 << 18);
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed traffic, largely on a small pool of atoms, loaded before use.
  task automatic random_traffic(input int count);
    logic [9:0]      idx;
    logic [OP_W-1:0] op;
    int              roll;
    for (int n = 0; n < count; n++) begin
      idx  = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 15)) : 10'($urandom);
      roll = $urandom_range(0, 99);
      if (!loaded[idx] || roll < 10) op = OP_LOAD;
      else if (roll < 30) op = OP_HALF;
      else if (roll < 50) op = OP_DRIFT;
      else if (roll < 82) op = has_ref[idx] ? OP_KDT : OP_SNAPSHOT;
      else if (roll < 94) op = OP_SNAPSHOT;
      else op = OP_NONE + 3'($urandom_range(0, 2));
      send_atom(op, idx, pick_word(), pick_word(), pick_word(),
                pick_word(), pick_word(), pick_word(), pick_mass());
    end
  endtask

  // Stimulus and verdict.
  initial begin
    logic [OP_W-1:0] op;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_data    = '0;
    n_sent      = 0;
    n_recv      = 0;
    idle_cycles = 0;
    hold_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default settings, written explicitly, then the directed cases.
    set_regs(31'd66, 31'd655360, 31'd655360, 31'd655360, 64'h1_0000_0000);
    send_atom(OP_LOAD, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
              32'h7FFF_FFFF, 32'h8000_0000, 32'd65536, 31'd0);
    send_atom(OP_LOAD, 10'd1023, -32'd100000, 32'd700000, 32'd5,
              32'd0, -32'd1, 32'd12345, 31'd0);
    send_atom(OP_HALF, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF);
    send_atom(OP_HALF, 10'd1023, 32'h8000_0000, 32'd65536, -32'd65536,
              32'd0, 32'd0, 32'd0, 31'd65536);
    // Positions outside the box are brought back by the drift.
    send_atom(OP_DRIFT, 10'd1023, '0, '0, '0, '0, '0, '0, '0);
    send_atom(OP_DRIFT, 10'd0, '0, '0, '0, '0, '0, '0, '0);
    send_atom(OP_SNAPSHOT, 10'd0, '0, '0, '0, '0, '0, '0, '0);
    send_atom(OP_SNAPSHOT, 10'd1023, '0, '0, '0, '0, '0, '0, '0);
    send_atom(OP_KDT, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1,
              '0, '0, '0, 31'd0);
    send_atom(OP_KDT, 10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              '0, '0, '0, 31'h7FFF_FFFF);
    send_atom(OP_KDT, 10'd0, 32'd400000, -32'd400000, 32'd0, '0, '0, '0, 31'd65536);
    op = OP_NONE;
    repeat (3) begin
      send_atom(op, 10'd0, '1, '1, '1, '1, '1, '1, '1);
      op = op + 3'd1;
    end
    send_atom(OP_LOAD, 10'd512, '1, '1, '1, '1, '1, '1, '1);
    send_atom(OP_SNAPSHOT, 10'd0, '0, '0, '0, '0, '0, '0, '0);
    random_traffic(230);

    // Smallest nonzero step and box, zero threshold.
    set_regs(31'd1, 31'd1, 31'd1, 31'd1, 64'd0);
    random_traffic(200);

    // Largest step, box and threshold; long receiver hold-off midway.
    set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, '1);
    random_traffic(100);
    hold_cycles = 400;
    random_traffic(150);
    wait_drain();

    // Zero box lengths on two axes.
    set_regs(31'd65536, 31'd0, 31'd655360, 31'd0, {$urandom, $urandom});
    random_traffic(250);

    // Moderate settings typical of use.
    set_regs(31'd6554, 31'd1 << 20, 31'd3 << 16, 31'd123456, 64'h10_0000_0000);
    random_traffic(250);

    // Random settings.
    set_regs($urandom_range(1, 1 << 20), $urandom_range(0, 1 << 24),
             $urandom_range(1, 1 << 24), $urandom, {$urandom >> 8, $urandom});
    random_traffic(300);

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
